/* rtl/core/fct_pkg.sv */
// ----------------------------------------------------------------------------
// fct_pkg: shared types and constants of the framed command tokenizer
// Holds default sizes, register indexes, status codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none
package fct_pkg;

   localparam int LINE_DEPTH_DEF    = 32;
   localparam int TABLE_ENTRIES_DEF = 4;
   localparam int NAME_CHARS_DEF    = 8;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] REG_FRAMING  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NAME_0   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NAME_1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NAME_2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NAME_3   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ARG_CNT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_IN_USE   = 3'd6;

   localparam logic [23:0] FRAMING_RESET = 24'd2893860;

   localparam logic [1:0] ST_MATCH    = 2'd0;
   localparam logic [1:0] ST_NO_MATCH = 2'd1;
   localparam logic [1:0] ST_BAD_ARGS = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_ARG    = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MATCH,
      S_HEADER,
      S_ARG_RD,
      S_ARG_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic store;      // write char into the line
      logic open;       // start char: clear line, open frame
      logic drop;       // full line: set overflow
      logic scan_start; // reset scan pointer and counters
      logic scan_step;  // examine one stored byte
      logic match_step; // compare one table entry
      logic arg_start;  // point at first argument byte
      logic arg_step;   // advance argument pointer
      logic close;      // end of frame cleanup
      logic rsp_load;   // load output register
      logic rsp_kind;
      logic rsp_last;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic is_start;
      logic is_end;
      logic in_frame;
      logic nonzero;
      logic full;
      logic scan_done;
      logic match_done;
      logic has_args;   // header followed by argument bytes
      logic arg_last;   // current argument byte is the last line byte
   } sts_type;

endpackage
`default_nettype wire

/* rtl/core/fct_ram.sv */
// ----------------------------------------------------------------------------
// fct_ram: generic single-port-write, single-port-read RAM
// Registered read data; contents undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
module fct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/core/fct_ctrl.sv */
// ----------------------------------------------------------------------------
// fct_ctrl: frame controller
// Sequences character intake, line scan, table match and result emission.
// ----------------------------------------------------------------------------
`default_nettype none
module fct_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             out_busy,
   input  wire fct_pkg::sts_type sts,
   output fct_pkg::ctl_type      ctl
);
   fct_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fct_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fct_pkg::S_IDLE: begin
            if (req_valid && sts.is_end && !sts.is_start) begin
               state_in = fct_pkg::S_SCAN;
            end
         end
         fct_pkg::S_SCAN: begin
            if (sts.scan_done) state_in = fct_pkg::S_MATCH;
         end
         fct_pkg::S_MATCH: begin
            if (sts.match_done) state_in = fct_pkg::S_HEADER;
         end
         fct_pkg::S_HEADER: begin
            if (!out_busy) begin
               state_in = sts.has_args ? fct_pkg::S_ARG_RD : fct_pkg::S_IDLE;
            end
         end
         fct_pkg::S_ARG_RD: state_in = fct_pkg::S_ARG_OUT;
         fct_pkg::S_ARG_OUT: begin
            if (!out_busy) begin
               state_in = sts.arg_last ? fct_pkg::S_IDLE : fct_pkg::S_ARG_RD;
            end
         end
         default: state_in = fct_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         fct_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (sts.is_start) begin
                  ctl.open = 1'b1;
               end else if (sts.is_end) begin
                  ctl.scan_start = 1'b1;
               end else if (sts.in_frame && sts.nonzero) begin
                  ctl.store = !sts.full;
                  ctl.drop  = sts.full;
               end
            end
         end
         fct_pkg::S_SCAN:  ctl.scan_step  = 1'b1;
         fct_pkg::S_MATCH: ctl.match_step = 1'b1;
         fct_pkg::S_HEADER: begin
            if (!out_busy) begin
               ctl.rsp_load  = 1'b1;
               ctl.rsp_kind  = fct_pkg::KIND_HEADER;
               ctl.rsp_last  = !sts.has_args;
               ctl.arg_start = 1'b1;
               ctl.close     = !sts.has_args;
            end
         end
         fct_pkg::S_ARG_RD: ;
         fct_pkg::S_ARG_OUT: begin
            if (!out_busy) begin
               ctl.rsp_load = 1'b1;
               ctl.rsp_kind = fct_pkg::KIND_ARG;
               ctl.rsp_last = sts.arg_last;
               ctl.arg_step = 1'b1;
               ctl.close    = sts.arg_last;
            end
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

/* rtl/core/fct_datapath.sv */
// ----------------------------------------------------------------------------
// fct_datapath: line buffer, scan counters, name matcher and result register
// Stores frame bytes, counts delimiters, matches the name and drives results.
// ----------------------------------------------------------------------------
`default_nettype none
module fct_datapath #(
   parameter int LINE_DEPTH    = fct_pkg::LINE_DEPTH_DEF,
   parameter int TABLE_ENTRIES = fct_pkg::TABLE_ENTRIES_DEF,
   parameter int NAME_CHARS    = fct_pkg::NAME_CHARS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [7:0]                    char_in,
   input  wire logic                          csr_we,
   input  wire logic [fct_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fct_pkg::CSR_DATA_W-1:0] csr_data,
   input  wire fct_pkg::ctl_type              ctl,
   output fct_pkg::sts_type                   sts,
   input  wire logic                          rsp_stall,
   output logic                               rsp_valid,
   output logic                               rsp_item_kind,
   output logic [1:0]                         rsp_status,
   output logic [1:0]                         rsp_command_index,
   output logic [5:0]                         rsp_arg_count,
   output logic [7:0]                         rsp_arg_byte,
   output logic                               rsp_is_separator,
   output logic                               rsp_last
);
   localparam int AW = $clog2(LINE_DEPTH);
   localparam int FW = $clog2(LINE_DEPTH + 1);
   localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int NW = $clog2(NAME_CHARS + 1);

   // configuration
   logic [23:0] framing_ff;
   logic [63:0] names_ff [4];
   logic [31:0] exp_cnt_ff;
   logic [2:0]  in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         framing_ff <= fct_pkg::FRAMING_RESET;
         for (int k = 0; k < 4; k++) names_ff[k] <= '0;
         exp_cnt_ff <= '0;
         in_use_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            fct_pkg::REG_FRAMING: framing_ff <= csr_data[23:0];
            fct_pkg::REG_NAME_0:  names_ff[0] <= csr_data;
            fct_pkg::REG_NAME_1:  names_ff[1] <= csr_data;
            fct_pkg::REG_NAME_2:  names_ff[2] <= csr_data;
            fct_pkg::REG_NAME_3:  names_ff[3] <= csr_data;
            fct_pkg::REG_ARG_CNT: exp_cnt_ff <= csr_data[31:0];
            fct_pkg::REG_IN_USE:  in_use_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   wire logic [7:0] start_c = framing_ff[7:0];
   wire logic [7:0] end_c   = framing_ff[15:8];
   wire logic [7:0] delim   = framing_ff[23:16];

   // frame state
   logic [FW-1:0] fill_ff;
   logic          in_frame_ff, ovf_ff;

   // scan state
   logic [FW-1:0] ptr_ff;        // scan / argument pointer
   logic          rd_pend_ff;    // RAM read data valid
   logic [FW-1:0] rd_idx_ff;     // index of byte in rd_data
   logic [5:0]    delims_ff;
   logic          has_delim_ff;
   logic [FW-1:0] name_len_ff;
   logic [63:0]   name_buf_ff;   // first NAME_CHARS line bytes
   logic          scan_done_ff;

   // match state
   logic [2:0]    ent_ff;
   logic          found_ff;
   logic [1:0]    idx_ff;
   logic [1:0]    st_ff;

   // one table entry compare per cycle
   logic [2:0]  used;
   logic [63:0] ent_name;
   logic [7:0]  exp_byte;
   logic        entry_ok;
   logic [NW-1:0] ent_len;
   logic        len_hit, bytes_eq;

   logic [7:0]    rd_data;
   logic [AW-1:0] rd_addr;

   assign rd_addr = ptr_ff[AW-1:0];

   fct_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line (
      .clock   (clock),
      .wr_en   (ctl.store),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (char_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         in_frame_ff <= 1'b0;
         ovf_ff      <= 1'b0;
      end else if (ctl.open) begin
         fill_ff     <= '0;
         in_frame_ff <= 1'b1;
         ovf_ff      <= 1'b0;
      end else if (ctl.close) begin
         fill_ff     <= '0;
         in_frame_ff <= 1'b0;
         ovf_ff      <= 1'b0;
      end else if (ctl.store) begin
         fill_ff <= fill_ff + FW'(1);
      end else if (ctl.drop) begin
         ovf_ff <= 1'b1;
      end
   end

   // Line scan: one RAM read per cycle; each byte arrives in the next cycle.
   logic [5:0] name_len_ext;
   assign name_len_ext = 6'(name_len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         scan_done_ff <= 1'b0;
      end else if (ctl.scan_start) begin
         ptr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         delims_ff    <= '0;
         has_delim_ff <= 1'b0;
         name_len_ff  <= fill_ff;
         name_buf_ff  <= '0;
         scan_done_ff <= 1'b0;
         ent_ff       <= '0;
         found_ff     <= 1'b0;
         idx_ff       <= '0;
         st_ff        <= ovf_ff ? fct_pkg::ST_OVERFLOW : fct_pkg::ST_NO_MATCH;
      end else if (ctl.scan_step) begin
         if (ptr_ff < fill_ff) begin
            ptr_ff <= ptr_ff + FW'(1);
         end
         rd_pend_ff <= (ptr_ff < fill_ff);
         rd_idx_ff  <= ptr_ff;
         if (rd_pend_ff) begin
            if (rd_data == delim) begin
               delims_ff <= delims_ff + 6'd1;
               if (!has_delim_ff) begin
                  has_delim_ff <= 1'b1;
                  name_len_ff  <= rd_idx_ff;
               end
            end
            if (32'(rd_idx_ff) < NAME_CHARS) begin
               name_buf_ff[8*rd_idx_ff[2:0] +: 8] <= rd_data;
            end
         end
         scan_done_ff <= !rd_pend_ff && !(ptr_ff < fill_ff);
      end else if (ctl.match_step) begin
         ent_ff <= ent_ff + 3'd1;
         if (!found_ff && !ovf_ff && entry_ok) begin
            found_ff <= 1'b1;
            idx_ff   <= ent_ff[1:0];
            st_ff    <= (exp_byte == {2'b00, delims_ff}) ? fct_pkg::ST_MATCH
                                                        : fct_pkg::ST_BAD_ARGS;
         end
      end else if (ctl.arg_start) begin
         ptr_ff <= name_len_ff + FW'(1);
      end else if (ctl.arg_step) begin
         ptr_ff <= ptr_ff + FW'(1);
      end
   end

   assign used = (32'(in_use_ff) > TABLE_ENTRIES) ? 3'(TABLE_ENTRIES) : in_use_ff;
   assign ent_name = names_ff[ent_ff[1:0]];
   assign exp_byte = exp_cnt_ff[8*ent_ff[1:0] +: 8];

   always_comb begin
      ent_len  = NW'(NAME_CHARS);
      bytes_eq = 1'b1;
      for (int i = NAME_CHARS - 1; i >= 0; i--) begin
         if (ent_name[8*i +: 8] == 8'd0) ent_len = NW'(i);
      end
      for (int i = 0; i < NAME_CHARS; i++) begin
         if (NW'(i) < ent_len && ent_name[8*i +: 8] != name_buf_ff[8*i +: 8]) begin
            bytes_eq = 1'b0;
         end
      end
      len_hit  = (name_len_ext == 6'(ent_len));
      entry_ok = (ent_ff < used) && len_hit && bytes_eq;
   end

   assign sts.is_start   = (char_in == start_c);
   assign sts.is_end     = (char_in == end_c);
   assign sts.in_frame   = in_frame_ff;
   assign sts.nonzero    = (char_in != 8'd0);
   assign sts.full       = (32'(fill_ff) >= LINE_DEPTH);
   assign sts.scan_done  = scan_done_ff;
   assign sts.match_done = (ent_ff >= 3'(TABLE_ENTRIES - 1)) || found_ff || ovf_ff;
   assign sts.has_args   = (st_ff == fct_pkg::ST_MATCH) && has_delim_ff &&
                           (32'(name_len_ff) + 1 < 32'(fill_ff));
   assign sts.arg_last   = (32'(ptr_ff) + 1 == 32'(fill_ff));

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (ctl.rsp_load) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_item_kind     <= ctl.rsp_kind;
         rsp_status        <= st_ff;
         rsp_command_index <= found_ff ? idx_ff : 2'd0;
         rsp_arg_count     <= delims_ff;
         rsp_arg_byte      <= ctl.rsp_kind ? rd_data : 8'd0;
         rsp_is_separator  <= ctl.rsp_kind && (rd_data == delim);
         rsp_last          <= ctl.rsp_last;
      end
   end
endmodule
`default_nettype wire

/* rtl/core/framed_command_tokenizer.sv */
// ----------------------------------------------------------------------------
// framed_command_tokenizer: framed serial command parser
// Buffers a framed line, matches its name against a small table and emits
// a status header plus the argument bytes.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  req_     in         valid / stall      char_in
//  rsp_     out        valid / stall      kind, status, index, count, byte,
//                                         separator, last
//  csr_     in         valid / ready      index, data
//
// An end character scans the line through the buffer's single read port, then
// matches one table entry a cycle (up to TABLE_ENTRIES entries), then emits
// one header and, for each argument byte, a buffer read and then an output
// register load.
// Reset is synchronous and clears frame state and configuration registers; no buffer clear.
// A stalled result holds the output register; input stalls while parsing.
`default_nettype none
module framed_command_tokenizer #(
   parameter int LINE_DEPTH    = fct_pkg::LINE_DEPTH_DEF,
   parameter int TABLE_ENTRIES = fct_pkg::TABLE_ENTRIES_DEF,
   parameter int NAME_CHARS    = fct_pkg::NAME_CHARS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [7:0]                     req_char_in,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_item_kind,
   output logic [1:0]                          rsp_status,
   output logic [1:0]                          rsp_command_index,
   output logic [5:0]                          rsp_arg_count,
   output logic [7:0]                          rsp_arg_byte,
   output logic                                rsp_is_separator,
   output logic                                rsp_last,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [fct_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fct_pkg::CSR_DATA_W-1:0] csr_data
);
   fct_pkg::ctl_type ctl;
   fct_pkg::sts_type sts;
   logic             out_busy;

   // always take configuration writes; the user must let them arrive only while idle, unchecked here
   assign csr_ready = 1'b1;

   // hold a new result while the previous one still waits
   assign out_busy = rsp_valid && rsp_stall;

   fct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_busy  (out_busy),
      .sts       (sts),
      .ctl       (ctl)
   );

   fct_datapath #(
      .LINE_DEPTH    (LINE_DEPTH),
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .NAME_CHARS    (NAME_CHARS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .char_in           (req_char_in),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .ctl               (ctl),
      .sts               (sts),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_status        (rsp_status),
      .rsp_command_index (rsp_command_index),
      .rsp_arg_count     (rsp_arg_count),
      .rsp_arg_byte      (rsp_arg_byte),
      .rsp_is_separator  (rsp_is_separator),
      .rsp_last          (rsp_last)
   );
endmodule
`default_nettype wire
